// File: design/esd_pkg.sv
// Shared types and constants for the escape sequence decoder.
// Used by esd_step and escape_sequence_decoder; no dependencies.
package esd_pkg;

	localparam int MAX_STRING_BYTES = 4096;
	localparam int LEN_W = 13;
	localparam int LEN_FIELD_MAX = (1 << LEN_W) - 1;
	localparam logic [LEN_W-1:0] COUNT_LIMIT =
		LEN_W'((MAX_STRING_BYTES < LEN_FIELD_MAX) ? MAX_STRING_BYTES : LEN_FIELD_MAX);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_V = 8'h76;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_TAB = 8'h09;
	localparam logic [7:0] CTL_VT = 8'h0B;
	localparam logic [7:0] CTL_BEL = 8'h07;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_DIGIT = 2'd1,
		ST_UNKNOWN   = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_NORMAL = 3'd0,
		PH_BSLASH = 3'd1,
		PH_DIG_A  = 3'd2,
		PH_DIG_B  = 3'd3
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic [7:0]       value;
		logic             is_hex;
		status_t          err;
		logic             stopped;
		logic [LEN_W-1:0] count;
	} dec_state_t;

	localparam dec_state_t STATE_RESET = '{
		phase:   PH_NORMAL,
		value:   8'd0,
		is_hex:  1'b0,
		err:     ST_OK,
		stopped: 1'b0,
		count:   '0
	};

	typedef struct packed {
		logic [LEN_W-1:0] length;
		status_t          status;
		logic             done;
		logic             byte_valid;
		logic [7:0]       data;
	} dec_result_t;

endpackage

// File: design/esd_step.sv
// One decode step: current state and one request in, next state and result out.
// Pure combinational logic; depends on esd_pkg.
module esd_step (
	input  esd_pkg::dec_state_t  cur,
	input  logic [7:0]           in_byte,
	input  logic                 end_of_string,
	output esd_pkg::dec_state_t  nxt,
	output logic                 res_valid,
	output esd_pkg::dec_result_t res
);
	import esd_pkg::*;

	function automatic logic is_oct(input logic [7:0] c);
		return c inside {[8'h30:8'h37]};
	endfunction

	function automatic logic is_hexd(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic [7:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c inside {[8'h30:8'h39]}) begin
			v = c - CH_ZERO;
		end else if (c inside {[8'h41:8'h5A]}) begin
			v = c - CH_UPPER_A + 8'd10;
		end else begin
			v = c - CH_LOWER_A + 8'd10;
		end
		return v;
	endfunction

	logic [7:0] digit;
	logic [7:0] hv;
	logic       emit;
	logic [7:0] emit_byte;

	assign digit = in_byte - CH_ZERO;
	assign hv    = hex_val(in_byte);

	always_comb begin
		nxt       = cur;
		emit      = 1'b0;
		emit_byte = 8'd0;
		res_valid = 1'b0;
		res       = '0;
		if (end_of_string) begin
			nxt        = STATE_RESET;
			res_valid  = 1'b1;
			res.done   = 1'b1;
			res.length = cur.count;
			res.status = cur.err;
			if (!cur.stopped && (cur.phase == PH_BSLASH || cur.phase == PH_DIG_A
					|| cur.phase == PH_DIG_B)) begin
				res.status = ST_TRUNCATED;
			end
		end else if (!cur.stopped) begin
			case (cur.phase)
				PH_BSLASH: begin
					nxt.phase = PH_NORMAL;
					case (in_byte)
						CH_BSLASH: begin emit = 1'b1; emit_byte = CH_BSLASH; end
						CH_R:      begin emit = 1'b1; emit_byte = CTL_CR; end
						CH_N:      begin emit = 1'b1; emit_byte = CTL_LF; end
						CH_T:      begin emit = 1'b1; emit_byte = CTL_TAB; end
						CH_V:      begin emit = 1'b1; emit_byte = CTL_VT; end
						CH_A:      begin emit = 1'b1; emit_byte = CTL_BEL; end
						CH_X: begin
							nxt.is_hex = 1'b1;
							nxt.value  = 8'd0;
							nxt.phase  = PH_DIG_A;
						end
						default: begin
							if (is_oct(in_byte)) begin
								nxt.is_hex = 1'b0;
								nxt.value  = {digit[1:0], 6'd0};
								nxt.phase  = PH_DIG_A;
							end else begin
								nxt.err     = ST_UNKNOWN;
								nxt.stopped = 1'b1;
							end
						end
					endcase
				end
				PH_DIG_A: begin
					if (cur.is_hex) begin
						if (!is_hexd(in_byte)) nxt.err = ST_BAD_DIGIT;
						nxt.value = {hv[3:0], 4'd0};
					end else begin
						if (!is_oct(in_byte)) nxt.err = ST_BAD_DIGIT;
						nxt.value = cur.value + {digit[4:0], 3'd0};
					end
					nxt.phase = PH_DIG_B;
				end
				PH_DIG_B: begin
					if (cur.is_hex) begin
						if (!is_hexd(in_byte)) nxt.err = ST_BAD_DIGIT;
						emit_byte = cur.value + hv;
					end else begin
						if (!is_oct(in_byte)) nxt.err = ST_BAD_DIGIT;
						emit_byte = cur.value + digit;
					end
					nxt.value = emit_byte;
					nxt.phase = PH_NORMAL;
					emit      = 1'b1;
				end
				default: begin
					nxt.phase = PH_NORMAL;
					if (in_byte == CH_BSLASH) begin
						nxt.phase = PH_BSLASH;
					end else begin
						emit      = 1'b1;
						emit_byte = in_byte;
					end
				end
			endcase
			if (emit) begin
				res_valid      = 1'b1;
				res.byte_valid = 1'b1;
				res.data       = emit_byte;
				if (cur.count < COUNT_LIMIT) begin
					nxt.count = cur.count + 1'b1;
				end
			end
		end
	end

endmodule

// File: design/escape_sequence_decoder.sv
// Top level of the C-style escape sequence decoder.
// Instantiates esd_step; depends on esd_pkg.
//
// Usage:
//   Input stream s_*: one raw string byte per request in s_tdata; s_tlast high
//   marks the end item, whose s_tdata is ignored.
//   Output stream m_*: zero or one result per request. A decoded byte comes with
//   m_tuser high. The answer to the end item comes with m_tlast high, carrying
//   the status and the decoded length (saturating at the count limit); the
//   decoder state is then cleared for the next string.
//   Bytes that open or continue an escape, and bytes after an unknown escape,
//   give no result.
// Pipeline: the input register loads at the accepting edge; the result register
//   loads when that request advances, which a full output stage can hold off.
// Throughput: one request per cycle when not stalled; the decode state updates in one step.
// Reset: arst_n clears the decode state and both stage valids.
// Stall: while m_tready is low the result register holds and the input
//   register fills once more, then s_tready drops until the output drains.
module escape_sequence_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [9:8] status, [22:10] out_length, [23] 0
	output logic        m_tuser,   // byte_valid
	output logic        m_tlast    // done_res
);
	import esd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	logic        res_valid;
	dec_result_t res;
	dec_result_t res_q;
	logic        out_free;
	logic        advance;

	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	esd_step u_step (
		.cur           (state_q),
		.in_byte       (byte_s1),
		.end_of_string (eos_s1),
		.nxt           (state_nxt),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= STATE_RESET;
			m_tvalid <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				m_tvalid <= advance && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tdata = {1'b0, res_q.length, res_q.status, res_q.data};
	assign m_tuser = res_q.byte_valid;
	assign m_tlast = res_q.done;

	a_byte_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != m_tlast))
		else $error("result is neither a byte nor a done report");

	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[22:10] <= COUNT_LIMIT))
		else $error("reported length beyond limit");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eos_s1 |=> (state_q == STATE_RESET))
		else $error("state not cleared after end item");

	a_stop_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.stopped |-> (state_q.phase == PH_NORMAL && state_q.err == ST_UNKNOWN))
		else $error("stopped decoder inside an escape");

endmodule
